// ===== rtl/core/a128_pkg.sv =====
// ----------------------------------------------------------------------------
// a128_pkg
// Shared types, operation codes and constants of the 128-bit execute unit.
// ----------------------------------------------------------------------------
package a128_pkg;

  localparam int IMM_WIDTH = 32;
  localparam int DIV_STAGES = 128;

  typedef logic [127:0] w128_t;
  typedef logic [4:0] op_t;

  localparam op_t OP_ADD          = 5'd0;
  localparam op_t OP_SUB          = 5'd1;
  localparam op_t OP_AND          = 5'd2;
  localparam op_t OP_OR           = 5'd3;
  localparam op_t OP_XOR          = 5'd4;
  localparam op_t OP_SHL          = 5'd5;
  localparam op_t OP_SHR          = 5'd6;
  localparam op_t OP_SAR          = 5'd7;
  localparam op_t OP_MUL          = 5'd8;
  localparam op_t OP_MADD         = 5'd9;
  localparam op_t OP_UDIV         = 5'd10;
  localparam op_t OP_SDIV         = 5'd11;
  localparam op_t OP_UREM         = 5'd12;
  localparam op_t OP_SREM         = 5'd13;
  localparam op_t OP_EQ           = 5'd14;
  localparam op_t OP_LT           = 5'd15;
  localparam op_t OP_LTU          = 5'd16;
  localparam op_t OP_LE           = 5'd17;
  localparam op_t OP_LEU          = 5'd18;
  localparam op_t OP_LDI          = 5'd19;
  localparam op_t OP_SHIFT_OR_IMM = 5'd20;

  localparam logic [1:0] MOD_SHL  = 2'd0;
  localparam logic [1:0] MOD_SEXT = 2'd1;
  localparam logic [1:0] MOD_ZEXT = 2'd2;
  localparam logic [1:0] MOD_NONE = 2'd3;

  // Per-item control and early result, carried alongside the datapath.
  typedef struct packed {
    logic  valid;
    logic  is_mul;
    logic  is_div;
    logic  use_rem;
    logic  neg;
    logic  wr;
    logic  pred;
    w128_t res;
  } a128_side_t;

endpackage

// ===== rtl/core/a128_operand.sv =====
// ----------------------------------------------------------------------------
// a128_operand
// First stage: build operand b from immediate or modified register, register.
// ----------------------------------------------------------------------------
module a128_operand import a128_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 valid_in,
  input  logic [4:0]           req_type,
  input  logic                 use_immediate,
  input  logic [63:0]          a_high,
  input  logic [63:0]          a_low,
  input  logic [63:0]          b_high,
  input  logic [63:0]          b_low,
  input  logic [63:0]          c_high,
  input  logic [63:0]          c_low,
  input  logic [8:0]           modifier,
  input  logic [31:0]          imm_raw,
  output logic                 valid,
  output op_t                  op,
  output w128_t                a,
  output w128_t                b,
  output w128_t                c,
  output logic [IMM_WIDTH-1:0] raw
);

  logic [6:0] amt;
  logic [6:0] sh;
  w128_t      bv;
  w128_t      bm;
  w128_t      b_next;

  always_comb begin
    amt = modifier[8:2];
    sh  = 7'(8'd128 - {1'b0, amt});
    bv  = {b_high, b_low};
    unique case (modifier[1:0])
      MOD_SHL:  bm = bv << amt;
      MOD_SEXT: bm = (amt == 7'd0) ? bv : w128_t'($signed(bv << sh) >>> sh);
      MOD_ZEXT: bm = (amt == 7'd0) ? bv : (bv & ~({128{1'b1}} << amt));
      MOD_NONE: bm = bv;
      default:  bm = bv;
    endcase
    if (use_immediate) begin
      b_next = {{(128-IMM_WIDTH){imm_raw[IMM_WIDTH-1]}}, imm_raw[IMM_WIDTH-1:0]};
    end else begin
      b_next = bm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= valid_in;
    end
    if (adv) begin
      op  <= req_type;
      a   <= {a_high, a_low};
      b   <= b_next;
      c   <= {c_high, c_low};
      raw <= imm_raw[IMM_WIDTH-1:0];
    end
  end

endmodule

// ===== rtl/core/a128_alu.sv =====
// ----------------------------------------------------------------------------
// a128_alu
// Basic operations, compares and divider operand prep; held 3 stages.
// ----------------------------------------------------------------------------
module a128_alu import a128_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 valid_in,
  input  op_t                  op,
  input  w128_t                a,
  input  w128_t                b,
  input  logic [IMM_WIDTH-1:0] raw,
  output a128_side_t           side,
  output w128_t                num,
  output w128_t                den
);

  a128_side_t s_next;
  w128_t      num_next;
  w128_t      den_next;
  logic       zb;
  logic       sgn;
  a128_side_t side_q [0:2];
  w128_t      num_q  [0:2];
  w128_t      den_q  [0:2];

  always_comb begin
    s_next       = '0;
    s_next.valid = valid_in;
    s_next.wr    = 1'b1;
    zb           = (b == '0);
    sgn          = (op == OP_SDIV) || (op == OP_SREM);
    case (op) inside
      OP_ADD:    s_next.res = a + b;
      OP_SUB:    s_next.res = a - b;
      OP_AND:    s_next.res = a & b;
      OP_OR:     s_next.res = a | b;
      OP_XOR:    s_next.res = a ^ b;
      OP_SHL:    s_next.res = a << b[6:0];
      OP_SHR:    s_next.res = a >> b[6:0];
      OP_SAR:    s_next.res = w128_t'($signed(a) >>> b[6:0]);
      OP_MUL, OP_MADD: s_next.is_mul = 1'b1;
      OP_UDIV, OP_SDIV: begin
        s_next.res    = '1;
        s_next.is_div = !zb;
        s_next.neg    = (op == OP_SDIV) && (a[127] ^ b[127]);
      end
      OP_UREM, OP_SREM: begin
        s_next.res     = a;
        s_next.is_div  = !zb;
        s_next.use_rem = 1'b1;
        s_next.neg     = (op == OP_SREM) && a[127];
      end
      OP_EQ: begin
        s_next.wr = 1'b0; s_next.pred = (a == b);
      end
      OP_LT: begin
        s_next.wr = 1'b0; s_next.pred = $signed(a) < $signed(b);
      end
      OP_LTU: begin
        s_next.wr = 1'b0; s_next.pred = a < b;
      end
      OP_LE: begin
        s_next.wr = 1'b0; s_next.pred = !($signed(b) < $signed(a));
      end
      OP_LEU: begin
        s_next.wr = 1'b0; s_next.pred = !(b < a);
      end
      OP_LDI:    s_next.res = {{(128-IMM_WIDTH){raw[IMM_WIDTH-1]}}, raw};
      OP_SHIFT_OR_IMM: s_next.res = (a << IMM_WIDTH) | {{(128-IMM_WIDTH){1'b0}}, raw};
      default:   s_next.wr = 1'b0;
    endcase
    num_next = (sgn && a[127]) ? -a : a;
    den_next = (sgn && b[127]) ? -b : b;
  end

  // Hold for two more stages to line up with the multiplier.
  always_ff @(posedge clk) begin
    if (rst) begin
      side_q[0].valid <= 1'b0;
      side_q[1].valid <= 1'b0;
      side_q[2].valid <= 1'b0;
    end else if (adv) begin
      side_q[0] <= s_next;
      side_q[1] <= side_q[0];
      side_q[2] <= side_q[1];
    end
    if (adv) begin
      num_q[0] <= num_next;
      num_q[1] <= num_q[0];
      num_q[2] <= num_q[1];
      den_q[0] <= den_next;
      den_q[1] <= den_q[0];
      den_q[2] <= den_q[1];
    end
  end

  assign side = side_q[2];
  assign num  = num_q[2];
  assign den  = den_q[2];

endmodule

// ===== rtl/core/a128_mul.sv =====
// ----------------------------------------------------------------------------
// a128_mul
// Three-stage 128x128 multiply (low half) with optional addend.
// ----------------------------------------------------------------------------
module a128_mul import a128_pkg::*; (
  input  logic  clk,
  input  logic  adv,
  input  logic  madd,
  input  w128_t a,
  input  w128_t b,
  input  w128_t c,
  output w128_t prod
);

  logic [63:0] p00, p01, p02, p03, p10, p11, p12, p20, p21, p30;
  w128_t       c2, c3, g0, g1;

  always_ff @(posedge clk) begin
    if (adv) begin
      // 32x32 partial products that land in the low 128 bits
      p00 <= a[31:0]  * b[31:0];
      p01 <= a[31:0]  * b[63:32];
      p02 <= a[31:0]  * b[95:64];
      p03 <= a[31:0]  * b[127:96];
      p10 <= a[63:32] * b[31:0];
      p11 <= a[63:32] * b[63:32];
      p12 <= a[63:32] * b[95:64];
      p20 <= a[95:64] * b[31:0];
      p21 <= a[95:64] * b[63:32];
      p30 <= a[127:96] * b[31:0];
      c2  <= madd ? c : '0;
      g0  <= w128_t'(p00) + (w128_t'(p01) << 32) + (w128_t'(p10) << 32)
           + (w128_t'(p02) << 64) + (w128_t'(p11) << 64);
      g1  <= (w128_t'(p20) << 64) + (w128_t'(p03) << 96) + (w128_t'(p12) << 96)
           + (w128_t'(p21) << 96) + (w128_t'(p30) << 96);
      c3  <= c2;
      prod <= g0 + g1 + c3;
    end
  end

endmodule

// ===== rtl/core/a128_div.sv =====
// ----------------------------------------------------------------------------
// a128_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module a128_div import a128_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  a128_side_t side_in,
  input  w128_t      num,
  input  w128_t      den,
  output a128_side_t side_out,
  output w128_t      quo,
  output w128_t      rem
);

  a128_side_t side_s [0:DIV_STAGES-1];
  w128_t      rem_s  [0:DIV_STAGES-1];
  w128_t      quo_s  [0:DIV_STAGES-1];
  w128_t      den_s  [0:DIV_STAGES-1];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    a128_side_t si;
    w128_t      ri, qi, di;
    logic [128:0] diff;

    if (k == 0) begin : g_first
      assign si = side_in;
      assign ri = '0;
      assign qi = num;
      assign di = den;
    end else begin : g_next
      assign si = side_s[k-1];
      assign ri = rem_s[k-1];
      assign qi = quo_s[k-1];
      assign di = den_s[k-1];
    end

    // shifted partial remainder is 129 bits; no borrow means subtract
    assign diff = {ri, qi[127]} - {1'b0, di};

    always_ff @(posedge clk) begin
      if (rst) begin
        side_s[k].valid <= 1'b0;
      end else if (adv) begin
        side_s[k] <= si;
      end
      if (adv) begin
        den_s[k] <= di;
        if (!diff[128]) begin
          rem_s[k] <= diff[127:0];
          quo_s[k] <= {qi[126:0], 1'b1};
        end else begin
          rem_s[k] <= {ri[126:0], qi[127]};
          quo_s[k] <= {qi[126:0], 1'b0};
        end
      end
    end
  end

  assign side_out = side_s[DIV_STAGES-1];
  assign quo      = quo_s[DIV_STAGES-1];
  assign rem      = rem_s[DIV_STAGES-1];

endmodule

// ===== rtl/core/alu128_execute_unit.sv =====
// ----------------------------------------------------------------------------
// alu128_execute_unit
// 128-bit integer execute unit: ALU, multiply, multiply-add, divide, compare.
// ----------------------------------------------------------------------------
// One operation enters per clock unless the pipeline is stalled. Each result
// passes one operand stage, three stages where the ALU and the 32x32-piece
// multiplier run side by side, 128 divider stages that each retire one
// quotient bit, and the output register. The divider depth sets the latency;
// all operations take the same path so results come out in order. A stall on
// the result channel, while a result is held, freezes the whole pipeline and
// is passed straight back as req_stall, so nothing is dropped or repeated.
module alu128_execute_unit import a128_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [4:0]  req_type,
  input  logic        use_immediate,
  input  logic [63:0] a_high,
  input  logic [63:0] a_low,
  input  logic [63:0] b_high,
  input  logic [63:0] b_low,
  input  logic [63:0] c_high,
  input  logic [63:0] c_low,
  input  logic [8:0]  modifier,
  input  logic [31:0] imm_raw,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [63:0] result_high,
  output logic [63:0] result_low,
  output logic        writes_register,
  output logic        predicate_value
);

  logic                 adv;
  logic                 s1_valid;
  op_t                  s1_op;
  w128_t                s1_a, s1_b, s1_c;
  logic [IMM_WIDTH-1:0] s1_raw;
  a128_side_t           s4_side;
  a128_side_t           div_in;
  w128_t                s4_num, s4_den, prod;
  a128_side_t           d_side;
  w128_t                d_quo, d_rem, d_val, final_res;

  // Advance everything unless a finished result is being held.
  assign adv       = !result_valid || !result_stall;
  assign req_stall = !adv;

  a128_operand u_operand (
    .clk, .rst, .adv,
    .valid_in (req_valid),
    .req_type, .use_immediate,
    .a_high, .a_low, .b_high, .b_low, .c_high, .c_low,
    .modifier, .imm_raw,
    .valid (s1_valid), .op (s1_op),
    .a (s1_a), .b (s1_b), .c (s1_c), .raw (s1_raw)
  );

  a128_alu u_alu (
    .clk, .rst, .adv,
    .valid_in (s1_valid), .op (s1_op),
    .a (s1_a), .b (s1_b), .raw (s1_raw),
    .side (s4_side), .num (s4_num), .den (s4_den)
  );

  a128_mul u_mul (
    .clk, .adv,
    .madd (s1_op == OP_MADD),
    .a (s1_a), .b (s1_b), .c (s1_c),
    .prod
  );

  // Merge the multiplier result before the divider.
  always_comb begin
    div_in = s4_side;
    if (s4_side.is_mul) begin
      div_in.res = prod;
    end
  end

  a128_div u_div (
    .clk, .rst, .adv,
    .side_in (div_in), .num (s4_num), .den (s4_den),
    .side_out (d_side), .quo (d_quo), .rem (d_rem)
  );

  // Apply the sign of a quotient or remainder; others pass the early result.
  always_comb begin
    d_val = d_side.use_rem ? d_rem : d_quo;
    if (d_side.is_div) begin
      final_res = d_side.neg ? -d_val : d_val;
    end else begin
      final_res = d_side.res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= d_side.valid;
    end
    if (adv) begin
      result_high     <= d_side.wr ? final_res[127:64] : 64'd0;
      result_low      <= d_side.wr ? final_res[63:0] : 64'd0;
      writes_register <= d_side.wr;
      predicate_value <= d_side.pred;
    end
  end

endmodule
